### hdl/sca_pkg.sv
// Shared types, size-class tables and status codes for the slab size-class allocator.
// No dependencies; every other file of the block but sca_ram imports it.
package sca_pkg;

   localparam int CLASS_COUNT     = 26;
   localparam int MAX_SMALL       = 2048;
   localparam int GRANULE_W       = 12;   // granule index bits inside one 64 KiB chunk
   localparam int CHUNK_FIELD_W   = 10;   // enough for the largest region (1024 chunks)
   localparam int HDR_W           = 11;   // owner (6) and class (5)
   localparam int DEF_NUM_OWNERS  = 4;
   localparam int DEF_NUM_CHUNKS  = 64;

   localparam logic [11:0] CLASS_BYTES [CLASS_COUNT] = '{
      12'd16, 12'd32, 12'd48, 12'd64, 12'd80, 12'd96, 12'd112, 12'd128,
      12'd160, 12'd192, 12'd224, 12'd256, 12'd320, 12'd384, 12'd448, 12'd512,
      12'd640, 12'd768, 12'd896, 12'd1024, 12'd1152, 12'd1280, 12'd1408,
      12'd1536, 12'd1792, 12'd2048};

   // block pitch in granules
   localparam logic [7:0] CLASS_STEP [CLASS_COUNT] = '{
      8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd10, 8'd12, 8'd14, 8'd16,
      8'd20, 8'd24, 8'd28, 8'd32, 8'd40, 8'd48, 8'd56, 8'd64, 8'd72, 8'd80,
      8'd88, 8'd96, 8'd112, 8'd128};

   // blocks per chunk: (64 KiB - 16) / block size
   localparam logic [11:0] CLASS_BLOCKS [CLASS_COUNT] = '{
      12'd4095, 12'd2047, 12'd1365, 12'd1023, 12'd819, 12'd682, 12'd585, 12'd511,
      12'd409, 12'd341, 12'd292, 12'd255, 12'd204, 12'd170, 12'd146, 12'd127,
      12'd102, 12'd85, 12'd73, 12'd63, 12'd56, 12'd51, 12'd46, 12'd42, 12'd36,
      12'd31};

   // blocks * step: granule offsets at or past this are beyond the last block
   localparam logic [11:0] CLASS_SPAN [CLASS_COUNT] = '{
      12'd4095, 12'd4094, 12'd4095, 12'd4092, 12'd4095, 12'd4092, 12'd4095, 12'd4088,
      12'd4090, 12'd4092, 12'd4088, 12'd4080, 12'd4080, 12'd4080, 12'd4088, 12'd4064,
      12'd4080, 12'd4080, 12'd4088, 12'd4032, 12'd4032, 12'd4080, 12'd4048, 12'd4032,
      12'd4032, 12'd3968};

   typedef enum logic [2:0] {
      ST_SLAB_ALLOC  = 3'd0,
      ST_SYS_ALLOC   = 3'd1,
      ST_LOCAL_FREE  = 3'd2,
      ST_REMOTE_FREE = 3'd3,
      ST_SYS_FREE    = 3'd4,
      ST_IGNORED     = 3'd5,
      ST_NULL        = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      BK_CLEAR, BK_IDLE, BK_AHEAD, BK_ALINK, BK_CARVE,
      BK_FHDR, BK_FMOD, BK_FHEAD, BK_RESP
   } bk_state_type;

   // classified request handed from front to back
   typedef struct packed {
      logic                     is_free;
      logic                     imm;        // answered without touching state
      status_type               imm_status;
      logic [5:0]               requester;
      logic [4:0]               size_class;
      logic [CHUNK_FIELD_W-1:0] chunk;
      logic [GRANULE_W-1:0]     granule;
      logic                     bad_inner;  // not granule aligned, or the header granule
   } item_type;

endpackage

### hdl/sca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sca_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/sca_front.sv
// Front end: request handshake, size-class lookup and region checks.
// Depends on sca_pkg; feeds sca_queue.
module sca_front #(
   parameter int NUM_OWNERS = sca_pkg::DEF_NUM_OWNERS,
   parameter int NUM_CHUNKS = sca_pkg::DEF_NUM_CHUNKS
) (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [5:0]        req_requester,
   input  logic [31:0]       req_request_size,
   input  logic [47:0]       req_free_address,
   input  logic [47:0]       region_base,
   input  logic              q_full,
   input  logic              clearing,
   output logic              q_push,
   output sca_pkg::item_type q_item
);
   import sca_pkg::*;

   logic [11:0] size_small;
   logic        oversize;
   logic [4:0]  cls;
   logic [47:0] offset;
   logic        outside;

   assign req_ready = !q_full && !clearing;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      size_small = (req_request_size == 32'd0) ? 12'd1 : req_request_size[11:0];
      oversize   = req_request_size > 32'(MAX_SMALL);
      cls        = 5'(CLASS_COUNT - 1);
      for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
         if (CLASS_BYTES[k] >= size_small) begin
            cls = 5'(k);
         end
      end
   end

   assign offset  = req_free_address - region_base;
   assign outside = (req_free_address < region_base) ||
                    (offset[47:16] >= 32'(NUM_CHUNKS));

   always_comb begin
      q_item            = '0;
      q_item.is_free    = req_opcode;
      q_item.requester  = req_requester;
      q_item.size_class = cls;
      q_item.chunk      = offset[16 +: CHUNK_FIELD_W];
      q_item.granule    = offset[15:4];
      q_item.bad_inner  = (offset[3:0] != 4'd0) || (offset[15:4] == 12'd0);
      q_item.imm        = 1'b0;
      q_item.imm_status = ST_SYS_ALLOC;
      if (!req_opcode) begin
         if (oversize || (32'(req_requester) >= 32'(NUM_OWNERS))) begin
            q_item.imm = 1'b1;
         end
      end else if (req_free_address == 48'd0) begin
         q_item.imm        = 1'b1;
         q_item.imm_status = ST_NULL;
      end else if (outside) begin
         q_item.imm        = 1'b1;
         q_item.imm_status = ST_SYS_FREE;
      end
   end
endmodule

### hdl/sca_queue.sv
// Two-entry queue of classified requests between front and back.
// Depends on sca_pkg for the entry type.
module sca_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sca_pkg::item_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output sca_pkg::item_type head_item
);
   import sca_pkg::*;

   item_type   data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign valid     = count_ff != 2'd0;
   assign head_item = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         data_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

### hdl/sca_back.sv
// Back end: free-list heads, link store, chunk headers, carving and the result register.
// Depends on sca_pkg and sca_ram; takes requests from sca_queue.
module sca_back #(
   parameter int NUM_OWNERS = sca_pkg::DEF_NUM_OWNERS,
   parameter int NUM_CHUNKS = sca_pkg::DEF_NUM_CHUNKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [47:0]       region_base,
   input  logic              q_valid,
   input  sca_pkg::item_type q_item,
   output logic              q_pop,
   output logic              clearing,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [47:0]       rsp_block_address,
   output logic [4:0]        rsp_size_class
);
   import sca_pkg::*;

   localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int NODE_W     = CHUNK_W + GRANULE_W;
   localparam int HE_W       = NODE_W + 1;            // valid bit on top
   localparam int HEAD_DEPTH = NUM_OWNERS * CLASS_COUNT;
   localparam int HEAD_W     = $clog2(HEAD_DEPTH);
   localparam int NEXT_W     = $clog2(NUM_CHUNKS + 1);

   bk_state_type state_ff, state_in;
   item_type     item_ff, item_in;
   logic [HEAD_W-1:0] h_ff, h_in, clr_ff, clr_in;
   logic [NODE_W-1:0] node_ff, node_in, walk_ff, walk_in;
   logic [11:0]       cnt_ff, cnt_in, div_ff, div_in;
   logic [7:0]        rem_ff, rem_in;
   logic [5:0]        owner_ff, owner_in;
   logic [4:0]        cls_ff, cls_in;
   logic [NEXT_W-1:0] next_chunk_ff, next_chunk_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [47:0]       rsp_addr_ff, rsp_addr_in;
   logic [4:0]        rsp_cls_ff, rsp_cls_in;

   logic              lh_we, rh_we, lk_we, hd_we;
   logic [HEAD_W-1:0] lh_waddr, rh_waddr, head_raddr;
   logic [HE_W-1:0]   lh_wdata, rh_wdata, lh_rdata, rh_rdata, lk_wdata, lk_rdata;
   logic [NODE_W-1:0] lk_waddr, lk_raddr;
   logic [CHUNK_W-1:0] hd_waddr, hd_raddr;
   logic [HDR_W-1:0]  hd_wdata, hd_rdata;

   logic [7:0]        step;
   logic [11:0]       blocks;
   logic [8:0]        r9;
   logic [NODE_W-1:0] free_node;
   logic [5:0]        hdr_owner;
   logic [4:0]        hdr_cls;

   sca_ram #(.WIDTH(HE_W), .DEPTH(HEAD_DEPTH), .ADDR_W(HEAD_W)) u_local (
      .clock, .wr_en(lh_we), .wr_addr(lh_waddr), .wr_data(lh_wdata),
      .rd_addr(head_raddr), .rd_data(lh_rdata));
   sca_ram #(.WIDTH(HE_W), .DEPTH(HEAD_DEPTH), .ADDR_W(HEAD_W)) u_remote (
      .clock, .wr_en(rh_we), .wr_addr(rh_waddr), .wr_data(rh_wdata),
      .rd_addr(head_raddr), .rd_data(rh_rdata));
   sca_ram #(.WIDTH(HE_W), .DEPTH(NUM_CHUNKS * 4096), .ADDR_W(NODE_W)) u_link (
      .clock, .wr_en(lk_we), .wr_addr(lk_waddr), .wr_data(lk_wdata),
      .rd_addr(lk_raddr), .rd_data(lk_rdata));
   sca_ram #(.WIDTH(HDR_W), .DEPTH(NUM_CHUNKS), .ADDR_W(CHUNK_W)) u_hdr (
      .clock, .wr_en(hd_we), .wr_addr(hd_waddr), .wr_data(hd_wdata),
      .rd_addr(hd_raddr), .rd_data(hd_rdata));

   assign step      = CLASS_STEP[cls_ff];
   assign blocks    = CLASS_BLOCKS[cls_ff];
   assign r9        = {rem_ff, div_ff[cnt_ff[3:0]]};
   assign free_node = {item_ff.chunk[CHUNK_W-1:0], item_ff.granule};
   assign hdr_owner = hd_rdata[10:5];
   assign hdr_cls   = hd_rdata[4:0];

   assign clearing          = state_ff == BK_CLEAR;
   assign q_pop             = (state_ff == BK_IDLE) && q_valid;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_size_class    = rsp_cls_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      h_in          = h_ff;
      clr_in        = clr_ff;
      node_in       = node_ff;
      walk_in       = walk_ff;
      cnt_in        = cnt_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      owner_in      = owner_ff;
      cls_in        = cls_ff;
      next_chunk_in = next_chunk_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_cls_in    = rsp_cls_ff;

      lh_we = 1'b0; lh_waddr = h_ff; lh_wdata = '0;
      rh_we = 1'b0; rh_waddr = h_ff; rh_wdata = '0;
      lk_we = 1'b0; lk_waddr = walk_ff; lk_wdata = '0;
      hd_we = 1'b0; hd_waddr = next_chunk_ff[CHUNK_W-1:0];
      hd_wdata = {owner_ff, cls_ff};
      head_raddr = h_ff;
      lk_raddr   = lh_rdata[NODE_W-1:0];
      hd_raddr   = q_item.chunk[CHUNK_W-1:0];

      unique case (state_ff)
         BK_CLEAR: begin
            lh_we = 1'b1; lh_waddr = clr_ff;
            rh_we = 1'b1; rh_waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == HEAD_DEPTH - 1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            head_raddr = HEAD_W'(32'(q_item.requester) * CLASS_COUNT + 32'(q_item.size_class));
            if (q_valid) begin
               item_in  = q_item;
               h_in     = head_raddr;
               cls_in   = q_item.size_class;
               owner_in = q_item.requester;
               if (q_item.imm) begin
                  res_status_in = q_item.imm_status;
                  state_in      = BK_RESP;
               end else if (q_item.is_free) begin
                  state_in = BK_FHDR;
               end else begin
                  state_in = BK_AHEAD;
               end
            end
         end
         BK_AHEAD: begin
            priority if (lh_rdata[NODE_W]) begin
               node_in  = lh_rdata[NODE_W-1:0];
               state_in = BK_ALINK;
            end else if (rh_rdata[NODE_W]) begin
               rh_we    = 1'b1;                     // whole remote stack moves over
               lk_raddr = rh_rdata[NODE_W-1:0];
               node_in  = rh_rdata[NODE_W-1:0];
               state_in = BK_ALINK;
            end else if (32'(next_chunk_ff) < NUM_CHUNKS) begin
               hd_we         = 1'b1;
               next_chunk_in = next_chunk_ff + 1'b1;
               node_in       = {next_chunk_ff[CHUNK_W-1:0], 12'd1};
               walk_in       = {next_chunk_ff[CHUNK_W-1:0], 12'd1};
               cnt_in        = 12'd0;
               state_in      = BK_CARVE;
            end else begin
               res_status_in = ST_SYS_ALLOC;
               state_in      = BK_RESP;
            end
         end
         BK_ALINK: begin
            lh_we         = 1'b1;
            lh_wdata      = lk_rdata;
            res_status_in = ST_SLAB_ALLOC;
            state_in      = BK_RESP;
         end
         BK_CARVE: begin
            lk_we    = 1'b1;
            lk_waddr = walk_ff;
            walk_in  = walk_ff + NODE_W'(step);
            cnt_in   = cnt_ff + 12'd1;
            if (cnt_ff == blocks - 12'd1) begin
               lk_wdata      = '0;
               lh_we         = 1'b1;
               lh_wdata      = {1'b1, node_ff + NODE_W'(step)};
               res_status_in = ST_SLAB_ALLOC;
               state_in      = BK_RESP;
            end else begin
               lk_wdata = {1'b1, walk_ff + NODE_W'(step)};
            end
         end
         BK_FHDR: begin
            owner_in = hdr_owner;
            cls_in   = hdr_cls;
            h_in     = HEAD_W'(32'(hdr_owner) * CLASS_COUNT + 32'(hdr_cls));
            div_in   = item_ff.granule - 12'd1;
            rem_in   = 8'd0;
            cnt_in   = 12'd11;
            if ((32'(item_ff.chunk) >= 32'(next_chunk_ff)) ||
                (32'(hdr_cls) >= CLASS_COUNT) || (32'(hdr_owner) >= NUM_OWNERS) ||
                item_ff.bad_inner ||
                ((item_ff.granule - 12'd1) >= CLASS_SPAN[hdr_cls])) begin
               res_status_in = ST_IGNORED;
               state_in      = BK_RESP;
            end else begin
               state_in = BK_FMOD;
            end
         end
         BK_FMOD: begin
            // restoring remainder of (granule - 1) by the block pitch, one bit a cycle
            rem_in = (r9 >= {1'b0, step}) ? 8'(r9 - {1'b0, step}) : r9[7:0];
            cnt_in = cnt_ff - 12'd1;
            if (cnt_ff == 12'd0) begin
               if (rem_in != 8'd0) begin
                  res_status_in = ST_IGNORED;
                  state_in      = BK_RESP;
               end else begin
                  state_in = BK_FHEAD;
               end
            end
         end
         BK_FHEAD: begin
            lk_we    = 1'b1;
            lk_waddr = free_node;
            if (item_ff.requester == owner_ff) begin
               lk_wdata      = lh_rdata;
               lh_we         = 1'b1;
               lh_wdata      = {1'b1, free_node};
               res_status_in = ST_LOCAL_FREE;
            end else begin
               lk_wdata      = rh_rdata;
               rh_we         = 1'b1;
               rh_wdata      = {1'b1, free_node};
               res_status_in = ST_REMOTE_FREE;
            end
            state_in = BK_RESP;
         end
         BK_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = '0;
               rsp_cls_in    = '0;
               if (res_status_ff == ST_SLAB_ALLOC) begin
                  rsp_addr_in = region_base + 48'({node_ff, 4'b0000});
               end
               if ((res_status_ff == ST_SLAB_ALLOC) || (res_status_ff == ST_LOCAL_FREE) ||
                   (res_status_ff == ST_REMOTE_FREE)) begin
                  rsp_cls_in = cls_ff;
               end
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CLEAR;
         clr_ff        <= '0;
         next_chunk_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         next_chunk_ff <= next_chunk_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff       <= item_in;
      h_ff          <= h_in;
      node_ff       <= node_in;
      walk_ff       <= walk_in;
      cnt_ff        <= cnt_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      owner_ff      <= owner_in;
      cls_ff        <= cls_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cls_ff    <= rsp_cls_in;
   end

   a_chunk_bound: assert property (@(posedge clock) disable iff (reset)
      32'(next_chunk_ff) <= NUM_CHUNKS)
      else $error("carved chunk count past region");
   a_carve_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CARVE) |-> (cnt_ff < blocks))
      else $error("carve walked past last block");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !q_valid)
      else $error("request queued during head clear");
   a_carve_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_AHEAD && state_in == BK_CARVE) |=>
      (next_chunk_ff == $past(next_chunk_ff) + 1'b1))
      else $error("carve did not claim a chunk");
endmodule

### hdl/slab_size_class_allocator.sv
// Top level of the slab size-class allocator: region base register, front, queue, back.
// Depends on sca_pkg, sca_front, sca_queue, sca_back (and sca_ram through sca_back).
//
//  channel   direction  handshake             payload
//  req       in         req_valid/req_ready   opcode, requester, request_size, free_address
//  rsp       out        rsp_valid/rsp_ready   status, block_address, size_class
//  csr       in         csr_wr_en             csr_wr_data (region base, low 16 bits dropped)
//
// Path of each request, from queue pop to result register:
//   system / null / out-of-region answers: straight to the result.
//   allocate from a local or remote list: head read, link read, result.
//   allocate that carves a chunk: head read, one link write a cycle per block (31 to 4095).
//   free: header read, bit-serial remainder check of the block offset, head update, result.
// After reset the head stores (NUM_OWNERS * 26 entries, 104 by default) are swept to empty,
// with req_ready low. The two-entry queue keeps accepting, until it is full, while the back
// end works or while a result waits in the output register for rsp_ready.
module slab_size_class_allocator #(
   parameter int NUM_OWNERS = sca_pkg::DEF_NUM_OWNERS,
   parameter int NUM_CHUNKS = sca_pkg::DEF_NUM_CHUNKS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [5:0]  req_requester,
   input  logic [31:0] req_request_size,
   input  logic [47:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [47:0] rsp_block_address,
   output logic [4:0]  rsp_size_class,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data
);
   import sca_pkg::*;

   logic [47:0] region_base_ff, region_base_in;
   logic        q_full, q_push, q_pop, q_valid, clearing;
   item_type    push_item, head_item;

   // base is always chunk aligned
   assign region_base_in = csr_wr_en ? {csr_wr_data[47:16], 16'h0000} : region_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
      end else begin
         region_base_ff <= region_base_in;
      end
   end

   sca_front #(.NUM_OWNERS(NUM_OWNERS), .NUM_CHUNKS(NUM_CHUNKS)) u_front (
      .req_valid, .req_ready, .req_opcode, .req_requester, .req_request_size,
      .req_free_address, .region_base(region_base_ff), .q_full, .clearing,
      .q_push, .q_item(push_item));

   sca_queue u_queue (
      .clock, .reset, .push(q_push), .push_item, .pop(q_pop), .full(q_full),
      .valid(q_valid), .head_item);

   sca_back #(.NUM_OWNERS(NUM_OWNERS), .NUM_CHUNKS(NUM_CHUNKS)) u_back (
      .clock, .reset, .region_base(region_base_ff), .q_valid, .q_item(head_item),
      .q_pop, .clearing, .rsp_valid, .rsp_ready, .rsp_status, .rsp_block_address,
      .rsp_size_class);
endmodule

### tb/sv/tb_top.sv
// Self-checking bench for slab_size_class_allocator: random and directed alloc/free requests,
// an in-order scoreboard class holding its own allocator state. Depends on sca_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sca_pkg::*;

   localparam int OWNERS      = 4;
   localparam int CHUNKS      = 64;
   localparam int HEADS       = OWNERS * CLASS_COUNT;
   localparam int WATCH_LIMIT = 30000;   // idle cycles; covers a 4095-block carve plus long stalls
   localparam logic [22:0] LINK_VALID = 23'h400000;

   typedef struct {
      status_type  status;
      logic [47:0] addr;
      logic [4:0]  cls;
   } alloc_result_type;

   typedef struct {
      logic [47:0] addr;
      logic [5:0]  owner;
   } live_block_type;

   // Allocator predictor plus the in-order queue of predicted answers.
   class alloc_scoreboard_type;
      logic [47:0]      base;
      logic [22:0]      local_top[HEADS];
      logic [22:0]      remote_top[HEADS];
      logic [22:0]      next_link[CHUNKS*4096];
      logic [11:0]      chunk_tag[CHUNKS];
      int unsigned      chunks_used;
      alloc_result_type pending[$];
      int               errors;

      function new();
         base = '0;
         chunks_used = 0;
         errors = 0;
         foreach (local_top[i]) begin
            local_top[i] = '0;
            remote_top[i] = '0;
         end
         foreach (chunk_tag[i]) chunk_tag[i] = '0;
         foreach (next_link[i]) next_link[i] = '0;
      endfunction

      // split a fresh chunk into ascending linked blocks; returns the head or empty
      function logic [22:0] carve_chunk(int unsigned owner, int unsigned cls);
         int unsigned ch, step, count, first, nd;
         if (chunks_used >= CHUNKS) return '0;
         ch = chunks_used++;
         chunk_tag[ch] = {1'b1, 6'(owner), 5'(cls)};
         step  = 32'(CLASS_BYTES[cls]) / 16;
         count = (65536 - 16) / 32'(CLASS_BYTES[cls]);
         first = ch * 4096 + 1;
         for (int unsigned i = 0; i < count; i++) begin
            nd = first + i * step;
            next_link[nd] = (i + 1 < count) ? (LINK_VALID | 23'(nd + step)) : '0;
         end
         return LINK_VALID | 23'(first);
      endfunction

      function alloc_result_type note_request(logic op, logic [5:0] who, logic [31:0] size,
                                              logic [47:0] fa);
         alloc_result_type r;
         int unsigned sz, cls, h, nd, ch, inner, slot, owner;
         logic [22:0] head;
         logic [47:0] off;
         r.status = ST_SLAB_ALLOC;
         r.addr = '0;
         r.cls = '0;
         if (op == 1'b0) begin
            sz = (size == 0) ? 1 : size;
            if (sz > MAX_SMALL || who >= OWNERS) r.status = ST_SYS_ALLOC;
            else begin
               cls = 0;
               while (cls < CLASS_COUNT - 1 && CLASS_BYTES[cls] < sz) cls++;
               h = who * CLASS_COUNT + cls;
               head = local_top[h];
               if (!head[22]) begin
                  // local list dry: adopt the whole remote stack, else carve
                  head = remote_top[h];
                  remote_top[h] = '0;
                  if (!head[22]) head = carve_chunk(who, cls);
               end
               if (!head[22]) r.status = ST_SYS_ALLOC;
               else begin
                  nd = 32'(head[21:0]);
                  local_top[h] = next_link[nd];
                  r.addr = base + 48'(nd) * 48'd16;
                  r.cls = 5'(cls);
               end
            end
         end else if (fa == 0) r.status = ST_NULL;
         else begin
            off = fa - base;
            if (fa < base || off >= 48'(CHUNKS * 65536)) r.status = ST_SYS_FREE;
            else begin
               ch = 32'(off[21:16]);
               inner = 32'(off[15:0]);
               if (!chunk_tag[ch][11]) r.status = ST_IGNORED;
               else begin
                  cls = 32'(chunk_tag[ch][4:0]);
                  owner = 32'(chunk_tag[ch][10:5]);
                  slot = 32'(CLASS_BYTES[cls]);
                  if (cls >= CLASS_COUNT || owner >= OWNERS || inner < 16 ||
                      (inner - 16) % slot != 0 || (inner - 16) / slot >= (65536 - 16) / slot)
                     r.status = ST_IGNORED;
                  else begin
                     nd = ch * 4096 + inner / 16;
                     h = owner * CLASS_COUNT + cls;
                     if (who == owner) begin
                        next_link[nd] = local_top[h];
                        local_top[h] = LINK_VALID | 23'(nd);
                        r.status = ST_LOCAL_FREE;
                     end else begin
                        next_link[nd] = remote_top[h];
                        remote_top[h] = LINK_VALID | 23'(nd);
                        r.status = ST_REMOTE_FREE;
                     end
                     r.cls = 5'(cls);
                  end
               end
            end
         end
         pending.push_back(r);
         return r;
      endfunction

      function void check_result(logic [2:0] st, logic [47:0] addr, logic [4:0] cls);
         alloc_result_type w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result status %0d addr %h", $time, st, addr);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (st !== w.status) begin
            $display("%0t: status exp %0d got %0d", $time, w.status, st);
            errors++;
         end
         if (addr !== w.addr) begin
            $display("%0t: block_address exp %h got %h", $time, w.addr, addr);
            errors++;
         end
         if (cls !== w.cls) begin
            $display("%0t: size_class exp %0d got %0d", $time, w.cls, cls);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready, req_opcode;
   logic [5:0]  req_requester;
   logic [31:0] req_request_size;
   logic [47:0] req_free_address;
   logic        rsp_valid, rsp_ready;
   logic [2:0]  rsp_status;
   logic [47:0] rsp_block_address;
   logic [4:0]  rsp_size_class;
   logic        csr_wr_en;
   logic [47:0] csr_wr_data;

   alloc_scoreboard_type sb = new();
   live_block_type       live[$];   // blocks handed out and not yet freed
   bit                   hold_off_req;
   int                   idle_cycles = 0;

   slab_size_class_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_requester(req_requester), .req_request_size(req_request_size),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_block_address(rsp_block_address), .rsp_size_class(rsp_size_class),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly back-to-back, sometimes a short gap, rarely a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // offer one request, hold it until accepted, then predict its answer
   task automatic send_request(logic op, logic [5:0] who, logic [31:0] size, logic [47:0] fa);
      alloc_result_type r;
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_requester <= who;
      req_request_size <= size;
      req_free_address <= fa;
      do @(posedge clock); while (!req_ready);
      r = sb.note_request(op, who, size, fa);
      if (op == 1'b0 && r.status == ST_SLAB_ALLOC) live.push_back('{r.addr, who});
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic alloc(logic [5:0] who, logic [31:0] size);
      send_request(1'b0, who, size, 48'({$urandom, $urandom}));
   endtask

   task automatic release_block(logic [5:0] who, logic [47:0] fa);
      send_request(1'b1, who, $urandom, fa);
   endtask

   // region base may only move while nothing is in flight
   task automatic write_base(logic [47:0] value);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.base = value & 48'hFFFF_FFFF_0000;
   endtask

   task automatic random_request();
      int r, idx;
      live_block_type b;
      logic [5:0] who;
      r = $urandom_range(0, 99);
      if (r < 48 || (r < 85 && live.size() == 0)) begin
         who = ($urandom_range(0, 9) < 9) ? 6'($urandom_range(0, OWNERS - 1))
                                          : 6'($urandom_range(0, 63));
         case ($urandom_range(0, 9))
            0:       alloc(who, $urandom);
            1, 2:    alloc(who, $urandom_range(0, 128));
            default: alloc(who, $urandom_range(0, MAX_SMALL));
         endcase
      end else if (r < 85) begin
         idx = $urandom_range(0, live.size() - 1);
         b = live[idx];
         if ($urandom_range(0, 9) != 0) live.delete(idx);   // otherwise a double free later
         r = $urandom_range(0, 9);
         who = (r < 6) ? b.owner : (r < 9) ? 6'($urandom_range(0, OWNERS - 1))
                                           : 6'($urandom_range(0, 63));
         release_block(who, b.addr);
      end else begin
         // malformed frees: misaligned, header granule, unmarked chunk, wild, null
         who = 6'($urandom_range(0, 63));
         case ($urandom_range(0, 4))
            0: if (live.size() != 0)
                  release_block(who, live[$urandom_range(0, live.size() - 1)].addr +
                                48'($urandom_range(1, 2047)));
               else release_block(who, 48'd0);
            1: release_block(who, sb.base + 48'($urandom_range(0, CHUNKS - 1)) * 48'h10000);
            2: release_block(who, sb.base + 48'($urandom_range(0, CHUNKS - 1)) * 48'h10000 +
                                  48'($urandom_range(0, 65535)));
            3: release_block(who, 48'({$urandom, $urandom}));
            default: release_block(who, 48'd0);
         endcase
      end
   endtask

   // stimulus: directed corners, then three region-base phases of random traffic
   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= 1'b0;
      req_requester <= '0;
      req_request_size <= '0;
      req_free_address <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      hold_off_req = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_base(48'h0000_0000_FFFF);       // low bits dropped: region at zero
      alloc(6'd0, 32'd0);                   // zero counts as one byte, carves class 0
      alloc(6'd0, 32'd1);                   // next block from the local list
      alloc(6'd1, 32'd17);
      alloc(6'd2, 32'd2048);                // largest class
      alloc(6'd3, 32'd1152);
      alloc(6'd1, 32'd2049);                // just too large
      alloc(6'd2, 32'hFFFF_FFFF);
      alloc(6'd63, 32'd16);                 // requester without lists
      release_block(6'd0, 48'd0);           // null, although the region covers zero
      release_block(6'd0, 48'hFFFF_FFFF_FFFF);   // beyond the region
      release_block(6'd1, 48'h3F_0010);     // chunk never carved
      release_block(6'd1, 48'h01_0000);     // header granule of a marked chunk
      release_block(6'd1, 48'h01_0018);     // inside a block, not its start
      release_block(6'd2, 48'h02_FFF0);     // past the last block of the class
      release_block(6'd0, live[0].addr);    // owner frees locally
      release_block(6'd0, live[0].addr);    // double free, pushed again
      release_block(6'd2, live[1].addr);    // remote free
      release_block(6'd40, live[2].addr);   // unknown id frees remotely
      alloc(6'd0, 32'd16);
      alloc(6'd1, 32'd20);                  // owner 1 adopts its remote stack later
      alloc(6'd1, 32'd32);
      live.delete();

      repeat (500) random_request();
      write_base(48'hFFFF_FFFF_FFFF);       // top of the address space, results wrap
      live.delete();
      repeat (350) random_request();
      write_base(48'h5A5A_C3C3_8001);
      live.delete();
      repeat (200) random_request();
      hold_off_req = 1'b1;                  // receiver stalls, sender keeps offering
      repeat (330) random_request();

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      int stall_left;
      bit held;
      stall_left = 0;
      held = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_status, rsp_block_address, rsp_size_class);
         if (hold_off_req && !held) begin
            held = 1'b1;
            stall_left = 400;
         end else if (stall_left == 0 && rsp_valid && rsp_ready)
            stall_left = gap_len();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   // watchdog: too long without any handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (idle_cycles + 1 >= WATCH_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("TEST FAILED");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

endmodule
